>>> hdl/cbpf_pkg.sv
// Package for the classic BPF filter engine: field widths, codes, item types.
// No dependencies; used by the divider, program store, top level and testbench.
package cbpf_pkg;

  localparam int unsigned CmdW = 2;
  localparam int unsigned IdxW = 12;
  localparam int unsigned LenW = 13;

  localparam logic [31:0] KillAnswer  = 32'h8000_0000;
  localparam logic [31:0] ActionMask  = 32'hffff_0000;
  localparam logic [31:0] AllowAnswer = 32'h7fff_0000;
  localparam logic [31:0] RecordBytes = 32'd64;

  typedef enum logic [1:0] {
    CmdLoadInsn = 2'd0,
    CmdLoadWord = 2'd1,
    CmdRun      = 2'd2,
    CmdNone     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ClsLd   = 3'd0,
    ClsLdx  = 3'd1,
    ClsSt   = 3'd2,
    ClsStx  = 3'd3,
    ClsAlu  = 3'd4,
    ClsJmp  = 3'd5,
    ClsRet  = 3'd6,
    ClsMisc = 3'd7
  } cls_e;

  typedef enum logic [2:0] {
    StIdle,
    StFetch,
    StExec,
    StDiv,
    StDone
  } state_e;

  typedef struct packed {
    logic [15:0] opcode;
    logic [7:0]  jump_true;
    logic [7:0]  jump_false;
    logic [31:0] operand;
  } insn_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] index;
    logic [15:0] opcode;
    logic [7:0]  jump_true;
    logic [7:0]  jump_false;
    logic [31:0] operand;
    logic [12:0] program_length;
    logic        start_chain;
  } in_item_t;

  typedef struct packed {
    logic [31:0] return_value;
    logic [31:0] chain_result;
    logic        ended_by_fault;
  } out_item_t;

  // Divider handshake between the sequencer and the divide unit.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

  function automatic logic more_severe(logic [31:0] a, logic [31:0] b);
    return ((a & ActionMask) ^ KillAnswer) < ((b & ActionMask) ^ KillAnswer);
  endfunction

endpackage

>>> hdl/cbpf_if.sv
// Valid/ready channel interface carrying one item of a given payload type.
// Depends on cbpf_pkg only through the payload type passed by the user.
interface cbpf_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/cbpf_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on cbpf_pkg for the request and response types.
module cbpf_div
  import cbpf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [31:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;
endmodule

>>> hdl/cbpf_imem.sv
// Program store: synchronous single-port-write, one-read memory of instructions.
// Depends on cbpf_pkg for the instruction type.
module cbpf_imem
  import cbpf_pkg::*;
#(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  insn_t            wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output insn_t            rdata_o
);
  insn_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> hdl/classic_bpf_filter_engine_unit.sv
// Classic BPF filter engine: top level with the run sequencer and small stores.
// Depends on cbpf_pkg, cbpf_if, cbpf_imem and cbpf_div.
//
// Usage: one input channel carries items of four kinds. An instruction load
// writes one slot of the program store, a record load writes one of the 16
// call record words; these and no-op items give no result. A run item
// executes the stored program from slot 0 and gives one result item with the
// return value, the chain minimum after the run and a fault flag.
// Each executed instruction passes through a fetch state (one program store
// read) and an execute state; a division or modulo also waits in the divide
// state for the bit-serial divider. The program store read is registered,
// so fetch and execute are separate states. Scratch words are cleared by
// per-run valid bits.
// Reset clears the sequencer and sets the chain minimum to allow; program and
// record contents are undefined until written. While the receiver stalls the
// result waits in the output register and the block takes no further item.
module classic_bpf_filter_engine_unit
  import cbpf_pkg::*;
#(
  parameter int unsigned PROGRAM_DEPTH = 4096
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  cbpf_if.sink    in_i,
  cbpf_if.source  out_o
);
  localparam int unsigned AddrW = $clog2(PROGRAM_DEPTH);
  localparam logic [LenW-1:0] DepthLen = LenW'(PROGRAM_DEPTH);

  in_item_t in_item;
  assign in_item = in_i.data;

  state_e state_q, state_d;
  logic [31:0] acc_q, acc_d, x_q, x_d, chain_q, chain_d;
  logic [LenW:0] pc_q, pc_d;
  logic [LenW-1:0] len_q, len_d;
  logic [31:0] rec [16];
  logic [31:0] scr [16];
  logic [15:0] scr_vld_q, scr_vld_d;
  logic        scr_we;
  logic [3:0]  scr_wa;
  logic [31:0] scr_wd;
  out_item_t out_q, out_d;
  logic        ovalid_q, ovalid_d;
  logic        div_mod_q, div_mod_d;
  logic        accept;
  insn_t       insn;
  div_req_t    dreq;
  div_rsp_t    drsp;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == StIdle) && !ovalid_q;

  cbpf_imem #(.Depth(PROGRAM_DEPTH)) u_imem (
    .clk_i   (clk_i),
    .we_i    (accept && in_item.command == CmdLoadInsn &&
              {1'b0, in_item.index} < DepthLen),
    .waddr_i (in_item.index[AddrW-1:0]),
    .wdata_i ({in_item.opcode, in_item.jump_true, in_item.jump_false,
               in_item.operand}),
    .raddr_i (pc_q[AddrW-1:0]),
    .rdata_o (insn)
  );

  cbpf_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  always_ff @(posedge clk_i) begin
    if (accept && in_item.command == CmdLoadWord && in_item.index < 12'd16) begin
      rec[in_item.index[3:0]] <= in_item.operand;
    end
    if (scr_we) begin
      scr[scr_wa] <= scr_wd;
    end
  end

  // Execute-stage decode.
  logic [31:0] k, v, scr_rd, abs_rd;
  logic [7:0]  op;
  logic [2:0]  mode;
  logic        cond;
  logic [LenW:0] pc_next;
  assign k      = insn.operand;
  assign op     = {insn.opcode[7:4], 4'h0};
  assign mode   = insn.opcode[7:5];
  assign v      = insn.opcode[3] ? x_q : k;
  assign scr_rd = scr_vld_q[k[3:0]] ? scr[k[3:0]] : 32'd0;
  assign abs_rd = (k >= RecordBytes) ? 32'd0 : rec[k[5:2]];

  always_comb begin
    case (op)
      8'h10:   cond = acc_q == v;
      8'h20:   cond = acc_q > v;
      8'h30:   cond = acc_q >= v;
      default: cond = (acc_q & v) != 32'd0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    x_d       = x_q;
    pc_d      = pc_q;
    len_d     = len_q;
    chain_d   = chain_q;
    scr_vld_d = scr_vld_q;
    scr_we    = 1'b0;
    scr_wa    = k[3:0];
    scr_wd    = acc_q;
    out_d     = out_q;
    ovalid_d  = ovalid_q;
    div_mod_d = div_mod_q;
    dreq      = '{start: 1'b0, dividend: acc_q, divisor: v};
    pc_next   = pc_q + {{LenW{1'b0}}, 1'b1};
    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept && in_item.command == CmdRun) begin
          len_d     = (in_item.program_length > DepthLen) ? DepthLen
                                                           : in_item.program_length;
          acc_d     = '0;
          x_d       = '0;
          pc_d      = '0;
          scr_vld_d = '0;
          if (in_item.start_chain) begin
            chain_d = AllowAnswer;
          end
          state_d = StFetch;
        end
      end
      StFetch: begin
        if (pc_q >= {1'b0, len_q}) begin
          out_d.return_value   = KillAnswer;
          out_d.ended_by_fault = 1'b1;
          state_d = StDone;
        end else begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StFetch;
        pc_d    = pc_next;
        case (cls_e'(insn.opcode[2:0]))
          ClsLd: begin
            case (mode)
              3'd0:    acc_d = k;
              3'd4:    acc_d = RecordBytes;
              3'd3:    acc_d = scr_rd;
              default: acc_d = abs_rd;
            endcase
          end
          ClsLdx: begin
            case (mode)
              3'd0:    x_d = k;
              3'd4:    x_d = RecordBytes;
              default: x_d = scr_rd;
            endcase
          end
          ClsSt, ClsStx: begin
            scr_we = 1'b1;
            scr_wd = insn.opcode[0] ? x_q : acc_q;
            scr_vld_d[k[3:0]] = 1'b1;
          end
          ClsAlu: begin
            case (op)
              8'h00: acc_d = acc_q + v;
              8'h10: acc_d = acc_q - v;
              8'h20: acc_d = acc_q * v;
              8'h30, 8'h90: begin
                if (v == 32'd0) begin
                  out_d.return_value   = KillAnswer;
                  out_d.ended_by_fault = 1'b1;
                  state_d = StDone;
                end else begin
                  dreq.start = 1'b1;
                  div_mod_d  = op[7];
                  pc_d       = pc_q;
                  state_d    = StDiv;
                end
              end
              8'h40: acc_d = acc_q | v;
              8'h50: acc_d = acc_q & v;
              8'h60: acc_d = (v < 32'd32) ? acc_q << v[4:0] : 32'd0;
              8'h70: acc_d = (v < 32'd32) ? acc_q >> v[4:0] : 32'd0;
              8'h80: acc_d = 32'd0 - acc_q;
              8'ha0: acc_d = acc_q ^ v;
              default: acc_d = acc_q;
            endcase
          end
          ClsJmp: begin
            // A long jump can leave the range; the widened pc then faults.
            if (op == 8'h00) begin
              pc_d = (k >= 32'(PROGRAM_DEPTH)) ? {1'b1, {LenW{1'b0}}}
                                               : pc_next + (LenW+1)'(k);
            end else begin
              pc_d = pc_next + (LenW+1)'(cond ? insn.jump_true : insn.jump_false);
            end
          end
          ClsRet: begin
            out_d.return_value   = (insn.opcode[4:3] == 2'b10) ? acc_q : k;
            out_d.ended_by_fault = 1'b0;
            state_d = StDone;
          end
          default: begin
            if (insn.opcode[7]) begin
              acc_d = x_q;
            end else begin
              x_d = acc_q;
            end
          end
        endcase
      end
      StDiv: begin
        if (drsp.done) begin
          acc_d   = div_mod_q ? drsp.remainder : drsp.quotient;
          pc_d    = pc_next;
          state_d = StFetch;
        end
      end
      StDone: begin
        if (!ovalid_q) begin
          if (more_severe(out_q.return_value, chain_q)) begin
            chain_d = out_q.return_value;
          end
          out_d.chain_result = more_severe(out_q.return_value, chain_q)
                               ? out_q.return_value : chain_q;
          ovalid_d = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      chain_q   <= AllowAnswer;
      ovalid_q  <= 1'b0;
      pc_q      <= '0;
      scr_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      chain_q   <= chain_d;
      ovalid_q  <= ovalid_d;
      pc_q      <= pc_d;
      scr_vld_q <= scr_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    x_q       <= x_d;
    len_q     <= len_d;
    out_q     <= out_d;
    div_mod_q <= div_mod_d;
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_i.ready) else $error("item taken while running");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_o.ready) |=> (ovalid_q && $stable(out_q)))
    else $error("stalled result changed");
  a_chain_severe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> !more_severe(out_q.return_value, out_q.chain_result))
    else $error("chain result less severe than return");
`endif
endmodule

>>> bench/tb_classic_bpf_filter_engine_unit.sv
// Testbench for classic_bpf_filter_engine_unit: random filter programs and call
// records driven over the item channels, results checked against a predictor.
// Depends on cbpf_pkg, cbpf_if and the block's RTL.
module tb_classic_bpf_filter_engine_unit;
  import cbpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth       = 4096;
  localparam int unsigned NumItems    = 1000;
  localparam int unsigned IdleLimit   = 250000;

  // Load modes (code bits 7..5).
  localparam logic [2:0] ModeImm = 3'b000;
  localparam logic [2:0] ModeAbs = 3'b001;
  localparam logic [2:0] ModeMem = 3'b011;
  localparam logic [2:0] ModeLen = 3'b100;
  // ALU operations (code bits 7..4).
  localparam logic [3:0] OpAdd = 4'h0;
  localparam logic [3:0] OpSub = 4'h1;
  localparam logic [3:0] OpMul = 4'h2;
  localparam logic [3:0] OpDiv = 4'h3;
  localparam logic [3:0] OpOr  = 4'h4;
  localparam logic [3:0] OpAnd = 4'h5;
  localparam logic [3:0] OpLsh = 4'h6;
  localparam logic [3:0] OpRsh = 4'h7;
  localparam logic [3:0] OpNeg = 4'h8;
  localparam logic [3:0] OpMod = 4'h9;
  localparam logic [3:0] OpXor = 4'ha;
  // Jump operations (code bits 7..4).
  localparam logic [3:0] JmpAlways = 4'h0;
  localparam logic [3:0] JmpEq     = 4'h1;
  localparam logic [3:0] JmpGt     = 4'h2;
  localparam logic [3:0] JmpGe     = 4'h3;
  localparam logic [3:0] JmpSet    = 4'h4;
  // Return source bits 4..3 selecting the accumulator.
  localparam logic [1:0] RetFromA = 2'b10;

  class verdict_board;
    insn_t       prog[Depth];
    logic [31:0] rec[16];
    logic [31:0] chain_min;
    out_item_t   expected_verdicts[$];
    int unsigned errors;

    function new();
      chain_min = AllowAnswer;
      errors = 0;
    endfunction

    // Returns {fault, answer} for one run over the first len slots.
    function logic [32:0] evaluate(int unsigned len);
      longint unsigned pc;
      logic [31:0] a, x, k, v;
      logic [31:0] mem[16];
      logic [15:0] c;
      logic        t;
      a = '0;
      x = '0;
      pc = 0;
      foreach (mem[i]) mem[i] = '0;
      while (pc < len) begin
        c = prog[pc].opcode;
        k = prog[pc].operand;
        v = c[3] ? x : k;
        case (cls_e'(c[2:0]))
          ClsLd: begin
            if (c[7:5] == ModeImm) a = k;
            else if (c[7:5] == ModeLen) a = RecordBytes;
            else if (c[7:5] == ModeMem) a = mem[k[3:0]];
            else a = (k >= RecordBytes) ? '0 : rec[k[5:2]];
          end
          ClsLdx: begin
            if (c[7:5] == ModeImm) x = k;
            else if (c[7:5] == ModeLen) x = RecordBytes;
            else x = mem[k[3:0]];
          end
          ClsSt:  mem[k[3:0]] = a;
          ClsStx: mem[k[3:0]] = x;
          ClsAlu: begin
            case (c[7:4])
              OpAdd: a = a + v;
              OpSub: a = a - v;
              OpMul: a = a * v;
              OpDiv, OpMod: begin
                if (v == 0) return {1'b1, KillAnswer};
                a = (c[7:4] == OpDiv) ? a / v : a % v;
              end
              OpOr:  a = a | v;
              OpAnd: a = a & v;
              OpLsh: a = (v < 32) ? a << v : '0;
              OpRsh: a = (v < 32) ? a >> v : '0;
              OpNeg: a = -a;
              OpXor: a = a ^ v;
              default: ;
            endcase
          end
          ClsJmp: begin
            if (c[7:4] == JmpAlways) begin
              pc += k;
            end else begin
              if (c[7:4] == JmpEq) t = (a == v);
              else if (c[7:4] == JmpGt) t = (a > v);
              else if (c[7:4] == JmpGe) t = (a >= v);
              else t = ((a & v) != 0);
              pc += t ? prog[pc].jump_true : prog[pc].jump_false;
            end
          end
          ClsRet: return {1'b0, (c[4:3] == RetFromA) ? a : k};
          default: begin
            if (c[7]) a = x;
            else x = a;
          end
        endcase
        pc++;
      end
      return {1'b1, KillAnswer};
    endfunction

    function void note_item(in_item_t it);
      int unsigned len;
      logic [32:0] res;
      out_item_t   exp_v;
      case (cmd_e'(it.command))
        CmdLoadInsn: prog[it.index] = '{it.opcode, it.jump_true, it.jump_false, it.operand};
        CmdLoadWord: if (it.index < 16) rec[it.index[3:0]] = it.operand;
        CmdRun: begin
          len = (it.program_length > Depth) ? Depth : it.program_length;
          if (it.start_chain) chain_min = AllowAnswer;
          res = evaluate(len);
          // Lower action bits, read as a signed number, are more severe.
          if ($signed(res[31:16]) < $signed(chain_min[31:16])) chain_min = res[31:0];
          exp_v.return_value = res[31:0];
          exp_v.chain_result = chain_min;
          exp_v.ended_by_fault = res[32];
          expected_verdicts.push_back(exp_v);
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t exp_v;
      if (expected_verdicts.size() == 0) begin
        $error("result with no run pending: return_value %h", got.return_value);
        errors++;
        return;
      end
      exp_v = expected_verdicts.pop_front();
      if (got.return_value !== exp_v.return_value) begin
        $error("return_value expected %h actual %h", exp_v.return_value, got.return_value);
        errors++;
      end
      if (got.chain_result !== exp_v.chain_result) begin
        $error("chain_result expected %h actual %h", exp_v.chain_result, got.chain_result);
        errors++;
      end
      if (got.ended_by_fault !== exp_v.ended_by_fault) begin
        $error("ended_by_fault expected %b actual %b", exp_v.ended_by_fault,
               got.ended_by_fault);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cbpf_if #(.T(in_item_t))  in_ch ();
  cbpf_if #(.T(out_item_t)) out_ch ();

  classic_bpf_filter_engine_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  verdict_board board = new();
  int unsigned  runs_sent = 0;
  int unsigned  items_sent = 0;
  int unsigned  filled = 0;
  int unsigned  idle_cycles = 0;
  bit           calm = 1'b0;

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Stretches without any idling alternate with stretches of random gaps.
  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 63) == 0) calm = ~calm;
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom_range(1, 70);
      2: return '1;
      3: return KillAnswer;
      default: return $urandom;
    endcase
  endfunction

  function automatic insn_t make_insn();
    insn_t ins;
    cls_e  cls;
    cls = cls_e'($urandom_range(0, 7));
    ins.opcode = {($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00, 5'($urandom), cls};
    if ((cls == ClsLd || cls == ClsLdx) && $urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: ins.opcode[7:5] = ModeImm;
        1: ins.opcode[7:5] = ModeLen;
        2: ins.opcode[7:5] = ModeMem;
        default: ins.opcode[7:5] = ModeAbs;
      endcase
    end
    if (cls == ClsJmp && $urandom_range(0, 3) != 0) ins.opcode[7:4] = 4'($urandom_range(0, 4));
    if (cls == ClsAlu && $urandom_range(0, 3) != 0) ins.opcode[7:4] = 4'($urandom_range(0, 10));
    ins.jump_true  = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
    ins.jump_false = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
    ins.operand = (cls == ClsJmp && $urandom_range(0, 5) != 0) ? 32'($urandom_range(0, 3))
                                                               : pick_word();
    return ins;
  endfunction

  task automatic send(in_item_t it);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_item(it);
    if (it.command != CmdNone) items_sent++;
  endtask

  task automatic load_insn(int unsigned slot, insn_t ins);
    in_item_t it;
    it = '0;
    it.command = CmdLoadInsn;
    it.index = slot[11:0];
    it.opcode = ins.opcode;
    it.jump_true = ins.jump_true;
    it.jump_false = ins.jump_false;
    it.operand = ins.operand;
    it.program_length = 13'($urandom);
    it.start_chain = 1'($urandom);
    send(it);
  endtask

  task automatic load_word(int unsigned word, logic [31:0] value);
    in_item_t it;
    it = '0;
    it.command = CmdLoadWord;
    it.index = word[11:0];
    it.operand = value;
    it.opcode = 16'($urandom);
    send(it);
  endtask

  task automatic run_filter(int unsigned len, bit restart);
    in_item_t it;
    it = '0;
    it.command = CmdRun;
    it.index = 12'($urandom);
    it.program_length = len[12:0];
    it.start_chain = restart;
    send(it);
    runs_sent++;
  endtask

  function automatic insn_t code_of(cls_e cls, logic [3:0] op, logic src, logic [31:0] k);
    insn_t ins;
    ins.opcode = {8'h00, op, src, cls};
    ins.jump_true = 8'h00;
    ins.jump_false = 8'h00;
    ins.operand = k;
    return ins;
  endfunction

  task automatic random_sequence();
    int unsigned n;
    in_item_t    noise;
    insn_t       ins;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    for (int unsigned s = 0; s < n; s++) begin
      ins = make_insn();
      if (s == n - 1 && $urandom_range(0, 3) != 0) begin
        ins.opcode[2:0] = ClsRet;
        ins.opcode[4:3] = $urandom_range(0, 1) ? RetFromA : 2'($urandom);
      end
      load_insn(s, ins);
    end
    if (n > filled) filled = n;
    repeat ($urandom_range(0, 2)) load_word($urandom_range(0, 15), pick_word());
    if ($urandom_range(0, 7) == 0) load_word($urandom_range(16, 4095), $urandom);
    if ($urandom_range(0, 9) == 0) begin
      noise = in_item_t'({$urandom, $urandom, $urandom, $urandom});
      noise.command = CmdNone;
      send(noise);
    end
    run_filter(($urandom_range(0, 4) == 0) ? $urandom_range(0, filled) : n,
               $urandom_range(0, 3) == 0);
  endtask

  always forever begin : result_sink
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      out_ch.ready <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    out_ch.ready <= 1'b1;
    do @(posedge clk_i); while (out_ch.valid !== 1'b1);
    board.check_verdict(out_ch.data);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every record word is written before any program can read one.
    for (int unsigned w = 0; w < 16; w++) begin
      load_word(w, (w == 0) ? 32'h0 : (w == 15) ? 32'hffff_ffff : $urandom);
    end
    // An empty program runs off the end at once.
    run_filter(0, 1'b1);
    // Last record word through an unaligned offset, then divide by a zero index.
    load_insn(0, code_of(ClsLd, {ModeAbs, 1'b0}, 1'b0, 32'd63));
    load_insn(1, code_of(ClsAlu, OpDiv, 1'b1, 32'd0));
    filled = 2;
    run_filter(2, 1'b1);
    // Offset past the record, record size, and a return of the accumulator.
    load_insn(0, code_of(ClsLd, {ModeAbs, 1'b0}, 1'b0, 32'd64));
    load_insn(1, code_of(ClsLd, {ModeLen, 1'b0}, 1'b0, 32'd0));
    load_insn(2, code_of(ClsRet, {3'b000, RetFromA[1]}, RetFromA[0], 32'd0));
    filled = 3;
    run_filter(3, 1'b0);
    run_filter(2, 1'b0);
    // A less severe answer leaves the chain minimum alone.
    load_insn(0, code_of(ClsRet, 4'h0, 1'b0, AllowAnswer));
    run_filter(1, 1'b0);
    run_filter(1, 1'b1);

    while (items_sent < NumItems) random_sequence();

    // A far jump reaches the last slot for the longest and the clamped lengths.
    load_insn(0, code_of(ClsJmp, JmpAlways, 1'b0, 32'(Depth - 2)));
    load_insn(Depth - 1, code_of(ClsRet, 4'h0, 1'b0, AllowAnswer));
    run_filter(8191, 1'b0);
    run_filter(Depth, 1'b1);
    run_filter(Depth - 1, 1'b0);
    in_ch.valid <= 1'b0;

    while (board.expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/cbpf_pkg.sv
hdl/cbpf_if.sv
hdl/cbpf_div.sv
hdl/cbpf_imem.sv
hdl/classic_bpf_filter_engine_unit.sv
bench/tb_classic_bpf_filter_engine_unit.sv
